// ----- hw/rtl/sha256_pkg.sv -----
// SHA-256 constants and round functions shared by the core and its round unit.
package sha256_pkg;

  localparam int CountWidth = 61;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hw/rtl/sha256_message_digest_core.sv -----
// SHA-256 core taking one message byte per item and returning the digest.
// Ready stays high after a plain byte; a byte that fills a block holds ready low
// while the shared round unit runs one round per cycle.
// After a final item the core writes the marker, one zero byte per cycle up to the
// length field and eight length bytes, then runs one or two compressions and the output load.
// The digest waits in an output register while bytes go on; sync reset clears state and counters, not buffer or digest.
module sha256_message_digest_core import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  input  logic        empty_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word_0,
  output logic [31:0] digest_word_1,
  output logic [31:0] digest_word_2,
  output logic [31:0] digest_word_3,
  output logic [31:0] digest_word_4,
  output logic [31:0] digest_word_5,
  output logic [31:0] digest_word_6,
  output logic [31:0] digest_word_7
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_MARK, S_PAD, S_LEN, S_OUT
  } state_t;

  state_t state;
  state_t resume;
  word_t buffer [16];
  logic [CountWidth-1:0] byte_count;
  logic [5:0] pos;
  logic [2:0] len_idx;
  word_t chain [8];
  word_t digest [8];
  word_t chain_out [8];
  logic comp_start, comp_done;
  logic [63:0] bits;

  assign bits = {byte_count, 3'b000};
  assign ready = (state == S_IDLE);

  sha256_round u_round (
    .clk(clk), .rst(rst), .start(comp_start), .block_words(buffer),
    .chain_in(chain), .done(comp_done), .chain_out(chain_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resume <= S_IDLE;
      byte_count <= '0;
      pos <= '0;
      len_idx <= '0;
      chain <= InitHash;
      comp_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      comp_start <= 1'b0;
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid && ready) begin
            if (empty_message) begin
              state <= S_MARK;
            end else begin
              buffer[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= message_byte;
              byte_count <= byte_count + 1'b1;
              pos <= pos + 6'd1;
              if (pos == 6'd63) begin
                comp_start <= 1'b1;
                resume <= last_byte ? S_MARK : S_IDLE;
                state <= S_COMP;
              end else if (last_byte) begin
                state <= S_MARK;
              end
            end
          end
        end
        S_MARK: begin
          buffer[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= PadByte;
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            comp_start <= 1'b1;
            resume <= S_PAD;
            state <= S_COMP;
          end else begin
            state <= S_PAD;
          end
        end
        S_COMP: begin
          if (comp_done) begin
            chain <= chain_out;
            state <= resume;
          end
        end
        S_PAD: begin
          if (pos == LenOffset) begin
            state <= S_LEN;
            len_idx <= '0;
          end else begin
            buffer[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= 8'h00;
            pos <= pos + 6'd1;
            if (pos == 6'd63) begin
              comp_start <= 1'b1;
              resume <= S_PAD;
              state <= S_COMP;
            end
          end
        end
        S_LEN: begin
          buffer[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= bits[63 - 8*len_idx -: 8];
          pos <= pos + 6'd1;
          if (len_idx == 3'd7) begin
            comp_start <= 1'b1;
            resume <= S_OUT;
            state <= S_COMP;
          end else begin
            len_idx <= len_idx + 3'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            digest <= chain;
            chain <= InitHash;
            byte_count <= '0;
            pos <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest_word_0 = digest[0];
  assign digest_word_1 = digest[1];
  assign digest_word_2 = digest[2];
  assign digest_word_3 = digest[3];
  assign digest_word_4 = digest[4];
  assign digest_word_5 = digest[5];
  assign digest_word_6 = digest[6];
  assign digest_word_7 = digest[7];

endmodule

// ----- hw/rtl/sha256_round.sv -----
// SHA-256 compression engine: one round per cycle over a 16-word schedule window.
module sha256_round import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  word_t       block_words [16],
  input  word_t       chain_in [8],
  output logic        done,
  output word_t       chain_out [8]
);

  word_t w [16];
  word_t v [8];
  logic [5:0] round;
  logic busy;

  word_t w_new, wi, t1, t2;

  always_comb begin
    w_new = w[0] + ssig0(w[1]) + w[9] + ssig1(w[14]);
    wi = w[0];
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[round] + wi;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        round <= '0;
        w <= block_words;
        v <= chain_in;
      end else if (busy) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= w_new;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = chain_in[i] + v[i];
  end

endmodule
